### hw/rtl/csma_backoff_mac_controller_top_defines.svh
// ----------------------------------------------------------------------------
// csma backoff mac controller assertion macros
// property macros for the checker file
// ----------------------------------------------------------------------------
`ifndef CSMA_BACKOFF_MAC_CONTROLLER_TOP_DEFINES_SVH
`define CSMA_BACKOFF_MAC_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication under reset
`define CBMAC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cbmac: implication check failed");

// next-cycle implication under reset
`define CBMAC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbmac: next-cycle check failed");

`endif

### hw/rtl/cbmac_pkg.sv
// ----------------------------------------------------------------------------
// cbmac package
// types, codes and constants of the csma backoff mac controller
// ----------------------------------------------------------------------------
package cbmac_pkg;

  localparam int unsigned ActW      = 3;
  localparam int unsigned MedW      = 2;
  localparam int unsigned SlotsW    = 10;
  localparam int unsigned CwW       = 11;
  localparam int unsigned SlotLenW  = 16;
  localparam int unsigned StateOutW = 3;
  localparam int unsigned WinW      = 17;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam int unsigned MaxWindow = 1024;

  localparam logic [CwW-1:0]      CwReset      = 11'd16;
  localparam logic [SlotLenW-1:0] SlotLenReset = 16'd100;

  localparam logic [CfgIdxW-1:0] RegContentionWindow = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSlotTicks        = 1'd1;

  localparam logic [MedW-1:0] MedIdle = 2'd0;
  localparam logic [MedW-1:0] MedRecv = 2'd2;

  typedef enum logic [ActW-1:0] {
    ActTick       = 3'd0,
    ActMedChange  = 3'd1,
    ActFrameReady = 3'd2,
    ActTxSwitched = 3'd3,
    ActTxEnd      = 3'd4,
    ActRxDeliver  = 3'd5
  } action_e;

  typedef enum logic [StateOutW-1:0] {
    CodeSwitching = 3'd0,
    CodeListening = 3'd1,
    CodeDefer     = 3'd2,
    CodeBackoff   = 3'd3,
    CodeTransmit  = 3'd4,
    CodeReceive   = 3'd5
  } mac_code_e;

  typedef enum logic [5:0] {
    StSwitching = 6'b000001,
    StListening = 6'b000010,
    StDefer     = 6'b000100,
    StBackoff   = 6'b001000,
    StTransmit  = 6'b010000,
    StReceive   = 6'b100000
  } state_e;

  typedef struct packed {
    logic set_tx_mode;
    logic set_rx_mode;
    logic send_frame;
    logic frame_done;
    logic deliver_rx;
  } pulses_t;

  function automatic logic [StateOutW-1:0] state_code(input state_e st);
    logic [StateOutW-1:0] code;
    case (st)
      StSwitching: code = CodeSwitching;
      StListening: code = CodeListening;
      StDefer:     code = CodeDefer;
      StBackoff:   code = CodeBackoff;
      StTransmit:  code = CodeTransmit;
      StReceive:   code = CodeReceive;
      default:     code = CodeListening;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/cbmac_ifs.sv
// ----------------------------------------------------------------------------
// cbmac channel interfaces
// valid/ready channels for events in and results out
// ----------------------------------------------------------------------------
interface cbmac_evt_if import cbmac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ActW-1:0]     action;
  logic [MedW-1:0]     medium_req;
  logic [SlotsW-1:0]   random_slots;

  modport source (output valid, action, medium_req, random_slots, input ready);
  modport sink   (input valid, action, medium_req, random_slots, output ready);
endinterface

interface cbmac_res_if import cbmac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [StateOutW-1:0] mac_state;
  logic                 set_tx_mode;
  logic                 set_rx_mode;
  logic                 send_frame;
  logic                 frame_done;
  logic                 deliver_rx;

  modport source (output valid, mac_state, set_tx_mode, set_rx_mode, send_frame,
                  frame_done, deliver_rx, input ready);
  modport sink   (input valid, mac_state, set_tx_mode, set_rx_mode, send_frame,
                  frame_done, deliver_rx, output ready);
endinterface

### hw/rtl/csma_backoff_mac_controller_top.sv
// ----------------------------------------------------------------------------
// csma backoff mac controller
// carrier-sense mac state machine with slotted backoff, one result per event
// ----------------------------------------------------------------------------
//  channel   direction  transfer carries
//  evt_i     in         action, medium_req, random_slots
//  res_o     out        mac_state and five pulses
//  cfg       in         contention_window (0), slot_ticks (1)
//
//  one event per cycle sustained while results are taken; an event passes the input register, then the result register
//  the state update and slot counter compare sit between the two registers
//  reset returns to listening with no frame, no backoff count, default config
//  a stalled result holds; the input register still fills behind it
// ----------------------------------------------------------------------------
module csma_backoff_mac_controller_top import cbmac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  cbmac_evt_if.sink           evt_i,
  cbmac_res_if.source         res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic                in_valid_q;
  logic [ActW-1:0]     action_q;
  logic [MedW-1:0]     med_q;
  logic [SlotsW-1:0]   rnd_q;
  logic                in_ready;
  logic                advance;

  logic [CwW-1:0]      cw_q;
  logic [SlotLenW-1:0] slot_len_q;

  state_e              state_q, state_d;
  logic                pend_q, pend_d;
  logic                bo_valid_q, bo_valid_d;
  logic [SlotsW-1:0]   slots_q, slots_d;
  logic [SlotLenW-1:0] cnt_q, cnt_d;

  logic                 out_valid_q;
  logic [StateOutW-1:0] out_state_q;
  pulses_t              out_pulses_q;
  pulses_t              pulses;

  logic                pend_c;
  logic                med_idle;
  logic                med_recv;
  logic                act_event;
  logic [SlotLenW-1:0] slot_len;
  logic [SlotLenW:0]   cnt_inc;
  logic [WinW-1:0]     cw_ext;
  logic [WinW-1:0]     win;
  logic [WinW-1:0]     win_m1;
  logic [SlotsW-1:0]   draw;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_ready    = !in_valid_q || advance;
  assign evt_i.ready = in_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && evt_i.valid) begin
      action_q <= evt_i.action;
      med_q    <= evt_i.medium_req;
      rnd_q    <= evt_i.random_slots;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q       <= CwReset;
      slot_len_q <= SlotLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegContentionWindow: cw_q       <= cfg_wdata_i[CwW-1:0];
        RegSlotTicks:        slot_len_q <= cfg_wdata_i[SlotLenW-1:0];
        default: ;
      endcase
    end
  end

  // backoff draw
  always_comb begin
    cw_ext = WinW'(cw_q);
    if (cw_q == '0) begin
      win = WinW'(1);
    end else if (cw_ext > WinW'(MaxWindow)) begin
      win = WinW'(MaxWindow);
    end else begin
      win = cw_ext;
    end
    win_m1 = win - WinW'(1);
    if (WinW'(rnd_q) > win_m1) begin
      draw = win_m1[SlotsW-1:0];
    end else begin
      draw = rnd_q;
    end
  end

  assign slot_len  = (slot_len_q == '0) ? SlotLenW'(1) : slot_len_q;
  assign cnt_inc   = {1'b0, cnt_q} + (SlotLenW+1)'(1);
  assign med_idle  = (med_q == MedIdle);
  assign med_recv  = (med_q == MedRecv);
  assign act_event = (action_q inside {[ActMedChange:ActRxDeliver]});
  assign pend_c    = pend_q || (action_q == ActFrameReady);

  // next state
  always_comb begin
    state_d    = state_q;
    pend_d     = pend_c;
    bo_valid_d = bo_valid_q;
    slots_d    = slots_q;
    cnt_d      = cnt_q;
    pulses     = '0;

    case (state_q)
      StSwitching: begin
        if (action_q == ActMedChange) begin
          state_d = StListening;
        end
      end
      StDefer: begin
        if (action_q == ActMedChange) begin
          if (med_idle) begin
            state_d = StBackoff;
          end else if (med_recv) begin
            state_d = StReceive;
          end
        end
      end
      StBackoff: begin
        if (action_q == ActTick) begin
          if (slots_q == '0) begin
            state_d = StTransmit;
          end else if (cnt_inc >= {1'b0, slot_len}) begin
            cnt_d   = '0;
            slots_d = slots_q - SlotsW'(1);
            if (slots_q == SlotsW'(1)) begin
              state_d = StTransmit;
            end
          end else begin
            cnt_d = cnt_inc[SlotLenW-1:0];
          end
        end else if (action_q == ActMedChange && !med_idle) begin
          cnt_d   = '0;
          state_d = med_recv ? StReceive : StDefer;
        end
      end
      StTransmit: begin
        if (action_q == ActTxSwitched) begin
          pulses.send_frame = pend_c;
        end else if (action_q == ActTxEnd) begin
          pulses.frame_done = 1'b1;
          pend_d     = 1'b0;
          bo_valid_d = 1'b0;
          slots_d    = '0;
          cnt_d      = '0;
          state_d    = StSwitching;
        end
      end
      StReceive: begin
        if (action_q == ActRxDeliver) begin
          pulses.deliver_rx = 1'b1;
          state_d = StListening;
        end
      end
      default: ;
    endcase

    if (state_d == StListening && act_event) begin
      if (pend_c) begin
        state_d = med_idle ? StBackoff : StDefer;
      end else if (med_recv) begin
        state_d = StReceive;
      end
    end

    if (state_d != state_q) begin
      case (state_d)
        StBackoff: begin
          if (!bo_valid_d) begin
            slots_d    = draw;
            bo_valid_d = 1'b1;
          end
          cnt_d = '0;
        end
        StTransmit: begin
          pulses.set_tx_mode = 1'b1;
          bo_valid_d = 1'b0;
        end
        StSwitching: begin
          pulses.set_rx_mode = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StListening;
      pend_q     <= 1'b0;
      bo_valid_q <= 1'b0;
      slots_q    <= '0;
      cnt_q      <= '0;
    end else if (advance) begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      bo_valid_q <= bo_valid_d;
      slots_q    <= slots_d;
      cnt_q      <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_state_q  <= state_code(state_d);
      out_pulses_q <= pulses;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.mac_state   = out_state_q;
  assign res_o.set_tx_mode = out_pulses_q.set_tx_mode;
  assign res_o.set_rx_mode = out_pulses_q.set_rx_mode;
  assign res_o.send_frame  = out_pulses_q.send_frame;
  assign res_o.frame_done  = out_pulses_q.frame_done;
  assign res_o.deliver_rx  = out_pulses_q.deliver_rx;

endmodule

### hw/rtl/cbmac_chk.sv
// ----------------------------------------------------------------------------
// cbmac port checker
// result channel checks, bound to the controller top level
// ----------------------------------------------------------------------------
`include "csma_backoff_mac_controller_top_defines.svh"

module cbmac_chk import cbmac_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input logic [StateOutW-1:0] mac_state_i,
  input logic                 set_tx_mode_i,
  input logic                 set_rx_mode_i,
  input logic                 send_frame_i,
  input logic                 frame_done_i,
  input logic                 deliver_rx_i
);

  `CBMAC_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(mac_state_i) && $stable(frame_done_i))
  `CBMAC_ASSERT_IMP(a_tx_state, clk_i, rst_ni, res_valid_i && (set_tx_mode_i || send_frame_i), mac_state_i == CodeTransmit)
  `CBMAC_ASSERT_IMP(a_done_state, clk_i, rst_ni, res_valid_i && (set_rx_mode_i || frame_done_i), mac_state_i == CodeSwitching && set_rx_mode_i && frame_done_i)
  `CBMAC_ASSERT_IMP(a_dlv_state, clk_i, rst_ni, res_valid_i && deliver_rx_i, mac_state_i != CodeTransmit && mac_state_i != CodeSwitching && !set_tx_mode_i)

endmodule

bind csma_backoff_mac_controller_top cbmac_chk u_cbmac_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .mac_state_i   (res_o.mac_state),
  .set_tx_mode_i (res_o.set_tx_mode),
  .set_rx_mode_i (res_o.set_rx_mode),
  .send_frame_i  (res_o.send_frame),
  .frame_done_i  (res_o.frame_done),
  .deliver_rx_i  (res_o.deliver_rx)
);
